// ===== rtl/eic_pkg.sv =====
// ----------------------------------------------------------------------------
// eic_pkg: shared types and constants of the ease-in curve unit
// Curve codes, fixed-point constants, series divisors and their reciprocals,
// and the latencies that the lanes are aligned to.
// ----------------------------------------------------------------------------
package eic_pkg;

    // curve selector codes
    typedef enum logic [2:0] {
        OP_LINEAR  = 3'd0,
        OP_SINE    = 3'd1,
        OP_QUAD    = 3'd2,
        OP_CUBIC   = 3'd3,
        OP_QUARTIC = 3'd4,
        OP_QUINTIC = 3'd5,
        OP_EXP     = 3'd6,
        OP_CIRC    = 3'd7
    } op_t;

    // progress format is Q1.15
    localparam int          FRAC_BITS = 15;
    localparam logic [15:0] ONE_Q15   = 16'h8000;
    localparam logic [15:0] HALF_Q15  = 16'h4000;

    // internal series format is Q30
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;

    // one series step is three register stages
    localparam int STEP_LAT  = 3;
    localparam int SIN_STEPS = 7;
    localparam int EXP_STEPS = 12;

    // cosine divisors (2k)(2k-1) for k = 7 down to 1, and floor(2^32 / d)
    localparam logic [7:0]  SIN_DIV   [SIN_STEPS] = '{
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };
    localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
        32'd23598721, 32'd32537631, 32'd47721858, 32'd76695844,
        32'd143165576, 32'd357913941, 32'd2147483648
    };

    // exponential divisors n = 12 down to 1 (divide by one uses 2^32 - 1)
    localparam logic [7:0]  EXP_DIV   [EXP_STEPS] = '{
        8'd12, 8'd11, 8'd10, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1
    };
    localparam logic [31:0] EXP_RECIP [EXP_STEPS] = '{
        32'd357913941, 32'd390451572, 32'd429496729, 32'd477218588,
        32'd536870912, 32'd613566756, 32'd715827882, 32'd858993459,
        32'd1073741824, 32'd1431655765, 32'd2147483648, 32'd4294967295
    };

    // lane depths; the exponential lane is the longest and sets the rest
    localparam int EXP_SIDE  = 1 + EXP_STEPS * STEP_LAT;
    localparam int LANE_LAT  = 2 + EXP_STEPS * STEP_LAT + 1;
    localparam int SIN_CORE  = 2 + SIN_STEPS * STEP_LAT + 1;
    localparam int POW_CORE  = 3;
    localparam int SQRT_BITS = 16;
    localparam int CIRC_CORE = 1 + SQRT_BITS + 1;
    localparam int SIN_PAD   = LANE_LAT - SIN_CORE;
    localparam int POW_PAD   = LANE_LAT - POW_CORE;
    localparam int CIRC_PAD  = LANE_LAT - CIRC_CORE;

endpackage

// ===== rtl/eic_series_step.sv =====
// ----------------------------------------------------------------------------
// eic_series_step: one Horner step of a Q30 series
// Computes h' = 1 -/+ floor(floor(a*h / 2^30) / d) over three stages:
// product, reciprocal multiply, then remainder correction.
// ----------------------------------------------------------------------------
module eic_series_step
    import eic_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        a_in,
    input  logic [31:0]        h_in,
    input  logic [7:0]         d,
    input  logic [31:0]        m,
    input  logic               sub,
    output logic [31:0]        a_out,
    output logic signed [33:0] h_out
);

    logic [63:0]        prod1;
    logic [31:0]        v1_reg;
    logic [31:0]        a1_reg;
    logic [63:0]        prod2;
    logic [31:0]        q0_reg;
    logic [31:0]        v2_reg;
    logic [31:0]        a2_reg;
    logic [39:0]        qd;
    logic [39:0]        rem;
    logic [32:0]        q;
    logic [33:0]        h_next;
    logic signed [33:0] h_reg;
    logic [31:0]        a3_reg;

    // product of the multiplier and the running term, back to Q30
    assign prod1 = 64'(a_in) * 64'(h_in);

    // quotient estimate by reciprocal, low by at most one
    assign prod2 = 64'(v1_reg) * 64'(m);

    // correction and the new term
    always_comb
    begin
        qd     = 40'(q0_reg) * 40'(d);
        rem    = 40'(v2_reg) - qd;
        q      = (rem >= 40'(d)) ? (33'(q0_reg) + 33'd1) : 33'(q0_reg);
        h_next = sub ? (34'(ONE_Q30) - 34'(q)) : (34'(ONE_Q30) + 34'(q));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg <= prod1[61:30];
            a1_reg <= a_in;
            q0_reg <= prod2[63:32];
            v2_reg <= v1_reg;
            a2_reg <= a1_reg;
            h_reg  <= $signed(h_next);
            a3_reg <= a2_reg;
        end
    end

    assign a_out = a3_reg;
    assign h_out = h_reg;

endmodule

// ===== rtl/eic_power.sv =====
// ----------------------------------------------------------------------------
// eic_power: linear and power curves
// Square, cube, fourth and fifth power by a chain of rounded multiplies,
// one per stage, then padded to the common lane latency.
// ----------------------------------------------------------------------------
module eic_power
    import eic_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  op_t         op,
    input  logic [15:0] x,
    output logic [15:0] y
);

    logic [30:0] m1, m2, m3, m4;
    logic [30:0] r1, r2, r3, r4;
    logic [15:0] p2_1_reg, x1_reg;
    op_t         op1_reg;
    logic [15:0] p2_2_reg, p3_2_reg, x2_reg;
    op_t         op2_reg;
    logic [15:0] p2_3_reg, p3_3_reg, p4_3_reg, x3_reg;
    op_t         op3_reg;
    logic [15:0] sel;
    logic [15:0] pad_reg [POW_PAD];

    // rounded products back to Q15
    always_comb
    begin
        m1 = 31'(x) * 31'(x);
        r1 = m1 + 31'(HALF_Q15);
        m2 = 31'(p2_1_reg) * 31'(x1_reg);
        r2 = m2 + 31'(HALF_Q15);
        m3 = 31'(p3_2_reg) * 31'(x2_reg);
        r3 = m3 + 31'(HALF_Q15);
        m4 = 31'(p4_3_reg) * 31'(x3_reg);
        r4 = m4 + 31'(HALF_Q15);
    end

    // pick the requested power
    always_comb
    begin
        case (op3_reg)
            OP_LINEAR:  sel = x3_reg;
            OP_QUAD:    sel = p2_3_reg;
            OP_CUBIC:   sel = p3_3_reg;
            OP_QUARTIC: sel = p4_3_reg;
            default:    sel = r4[30:15];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_1_reg <= r1[30:15];
            x1_reg   <= x;
            op1_reg  <= op;
            p2_2_reg <= p2_1_reg;
            p3_2_reg <= r2[30:15];
            x2_reg   <= x1_reg;
            op2_reg  <= op1_reg;
            p2_3_reg <= p2_2_reg;
            p3_3_reg <= p3_2_reg;
            p4_3_reg <= r3[30:15];
            x3_reg   <= x2_reg;
            op3_reg  <= op2_reg;
            pad_reg[0] <= sel;
            for (int i = 1; i < POW_PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
    end

    assign y = pad_reg[POW_PAD-1];

endmodule

// ===== rtl/eic_sine.sv =====
// ----------------------------------------------------------------------------
// eic_sine: sine ease-in lane
// Angle by a fixed multiply, cosine by a seven-step Horner series in Q30,
// clamp, then 1 - cos rounded to Q15.
// ----------------------------------------------------------------------------
module eic_sine
    import eic_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] x,
    output logic [15:0] y
);

    logic [46:0]        tp;
    logic [30:0]        t_reg;
    logic [61:0]        t2p;
    logic [31:0]        t2_reg;
    logic [31:0]        a_w [SIN_STEPS];
    logic signed [33:0] h_w [SIN_STEPS];
    logic signed [33:0] h_last;
    logic [30:0]        c;
    logic [30:0]        diff;
    logic [15:0]        y_core_reg;
    logic [15:0]        pad_reg [SIN_PAD];

    // angle in Q30 and its square
    assign tp  = 47'(x) * 47'(HALF_PI_Q30);
    assign t2p = 62'(t_reg) * 62'(t_reg);

    // Horner chain for the cosine
    for (genvar i = 0; i < SIN_STEPS; i++)
    begin : g_step
        logic [31:0] a_in_w;
        logic [31:0] h_in_w;
        if (i == 0)
        begin : g_first
            assign a_in_w = t2_reg;
            assign h_in_w = ONE_Q30;
        end
        else
        begin : g_rest
            assign a_in_w = a_w[i-1];
            assign h_in_w = h_w[i-1][31:0];
        end
        eic_series_step u_step (
            .clk   (clk),
            .en    (en),
            .a_in  (a_in_w),
            .h_in  (h_in_w),
            .d     (SIN_DIV[i]),
            .m     (SIN_RECIP[i]),
            .sub   (1'b1),
            .a_out (a_w[i]),
            .h_out (h_w[i])
        );
    end

    // clamp cosine to [0, 1] and round 1 - cos to Q15
    always_comb
    begin
        h_last = h_w[SIN_STEPS-1];
        if (h_last < 0)
            c = '0;
        else if (h_last > $signed(34'(ONE_Q30)))
            c = 31'(ONE_Q30);
        else
            c = h_last[30:0];
        diff = 31'(ONE_Q30) - c + 31'(HALF_Q15);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg      <= tp[45:15];
            t2_reg     <= t2p[61:30];
            y_core_reg <= diff[30:15];
            pad_reg[0] <= y_core_reg;
            for (int i = 1; i < SIN_PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
    end

    assign y = pad_reg[SIN_PAD-1];

endmodule

// ===== rtl/eic_exp.sv =====
// ----------------------------------------------------------------------------
// eic_exp: exponential ease-in lane
// Splits 10x - 10 into a whole power of two and a fraction, evaluates 2^r
// by a twelve-step Horner series in Q30, then rounds by a shift of k + 15.
// ----------------------------------------------------------------------------
module eic_exp
    import eic_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] x,
    output logic [15:0] y
);

    logic [15:0] u;
    logic [18:0] w10;
    logic [19:0] ksum;
    logic [3:0]  k;
    logic [19:0] wfull;
    logic [3:0]  k1_reg;
    logic [14:0] w1_reg;
    logic        zero1_reg;
    logic [44:0] zp;
    logic [31:0] z_reg;
    logic [3:0]  k_reg    [EXP_SIDE];
    logic        zero_reg [EXP_SIDE];
    logic [31:0] a_w [EXP_STEPS];
    logic signed [33:0] h_w [EXP_STEPS];
    logic [4:0]  sh;
    logic [32:0] half;
    logic [32:0] sum;
    logic [32:0] shifted;
    logic [15:0] y_reg;

    // whole and fractional part of 10 - 10x, fraction in Q15
    always_comb
    begin
        u     = ONE_Q15 - x;
        w10   = 19'(u) * 19'd10;
        ksum  = 20'(w10) + 20'd32767;
        k     = ksum[18:15];
        wfull = (20'(k) << FRAC_BITS) - 20'(w10);
    end

    // fraction times ln2 in Q30
    assign zp = 45'(w1_reg) * 45'(LN2_Q30);

    // Horner chain for 2^r
    for (genvar i = 0; i < EXP_STEPS; i++)
    begin : g_step
        logic [31:0] a_in_w;
        logic [31:0] h_in_w;
        if (i == 0)
        begin : g_first
            assign a_in_w = z_reg;
            assign h_in_w = ONE_Q30;
        end
        else
        begin : g_rest
            assign a_in_w = a_w[i-1];
            assign h_in_w = h_w[i-1][31:0];
        end
        eic_series_step u_step (
            .clk   (clk),
            .en    (en),
            .a_in  (a_in_w),
            .h_in  (h_in_w),
            .d     (EXP_DIV[i]),
            .m     (EXP_RECIP[i]),
            .sub   (1'b0),
            .a_out (a_w[i]),
            .h_out (h_w[i])
        );
    end

    // divide by 2^k and round from Q30 to Q15
    always_comb
    begin
        sh      = 5'(k_reg[EXP_SIDE-1]) + 5'(FRAC_BITS);
        half    = 33'd1 << (sh - 5'd1);
        sum     = 33'(h_w[EXP_STEPS-1][31:0]) + half;
        shifted = sum >> sh;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg      <= k;
            w1_reg      <= wfull[14:0];
            zero1_reg   <= (x == '0);
            z_reg       <= 32'(zp[44:15]);
            k_reg[0]    <= k1_reg;
            zero_reg[0] <= zero1_reg;
            for (int i = 1; i < EXP_SIDE; i++)
            begin
                k_reg[i]    <= k_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
            end
            y_reg <= zero_reg[EXP_SIDE-1] ? '0 : shifted[15:0];
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/eic_circ.sv =====
// ----------------------------------------------------------------------------
// eic_circ: circular ease-in lane
// Square root of 1 - x^2 in Q30, one result bit per stage, rounded to
// nearest by the final remainder, then subtracted from one.
// ----------------------------------------------------------------------------
module eic_circ
    import eic_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] x,
    output logic [15:0] y
);

    logic [31:0] xx;
    logic [30:0] rem_reg  [SQRT_BITS+1];
    logic [15:0] root_reg [SQRT_BITS+1];
    logic [30:0] rem_next  [SQRT_BITS];
    logic [15:0] root_next [SQRT_BITS];
    logic [16:0] s_round;
    logic [15:0] y_core_reg;
    logic [15:0] pad_reg [CIRC_PAD];

    assign xx = 32'(x) * 32'(x);

    // one root bit per stage, most significant first
    always_comb
    begin
        for (int j = 0; j < SQRT_BITS; j++)
        begin
            logic [32:0] trial;
            trial = (33'(root_reg[j]) << (SQRT_BITS - j))
                  + (33'd1 << (2 * (SQRT_BITS - 1 - j)));
            if (33'(rem_reg[j]) >= trial)
            begin
                rem_next[j]  = rem_reg[j] - trial[30:0];
                root_next[j] = root_reg[j] | (16'd1 << (SQRT_BITS - 1 - j));
            end
            else
            begin
                rem_next[j]  = rem_reg[j];
                root_next[j] = root_reg[j];
            end
        end
    end

    // round to nearest: remainder above the root means the next integer
    always_comb
    begin
        if (32'(rem_reg[SQRT_BITS]) > 32'(root_reg[SQRT_BITS]))
            s_round = 17'(root_reg[SQRT_BITS]) + 17'd1;
        else
            s_round = 17'(root_reg[SQRT_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= 31'(32'(ONE_Q30) - xx);
            root_reg[0] <= '0;
            for (int j = 0; j < SQRT_BITS; j++)
            begin
                rem_reg[j+1]  <= rem_next[j];
                root_reg[j+1] <= root_next[j];
            end
            y_core_reg <= 16'(17'(ONE_Q15) - s_round);
            pad_reg[0] <= y_core_reg;
            for (int i = 1; i < CIRC_PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
    end

    assign y = pad_reg[CIRC_PAD-1];

endmodule

// ===== rtl/ease_in_curve_unit.sv =====
// ----------------------------------------------------------------------------
// ease_in_curve_unit: pipelined ease-in easing curves
// Each transaction carries a curve code op and a Q1.15 progress x; the
// block returns the eased value y in Q1.15, rounded to nearest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid / item_stall carries op and x; a transaction
//   is taken when item_valid is high and item_stall is low. Progress above
//   1.0 is treated as 1.0.
//   Output channel result_valid / result_stall carries y, one result per
//   transaction, in the order the transactions were taken.
//   Pipeline: the input register loads at the accepting edge, then 39
//   lane stages and the output register follow before result_valid. The
//   longest lane is the exponential one (twelve series steps of three
//   stages).
//   Throughput: one transaction per cycle unless result_stall holds a result;
//   every multiplier and every series step is its own pipeline stage.
//   Reset clears all valid bits; the pipeline then accepts at once.
//   While a result waits under result_stall the whole pipeline holds and
//   item_stall is raised; nothing is lost or repeated. item_stall follows
//   result_stall in the same cycle.
// ----------------------------------------------------------------------------
module ease_in_curve_unit
    import eic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  op,
    input  logic [15:0] x,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] y
);

    logic        en;
    logic        vld_reg [LANE_LAT+1];
    op_t         op_reg  [LANE_LAT+1];
    logic [15:0] x0_reg;
    logic [15:0] y_pow, y_sin, y_exp, y_circ;
    logic [15:0] y_sel;
    logic        res_vld_reg;
    logic [15:0] y_reg;

    // pipeline advances unless a finished result is held up
    assign en         = !res_vld_reg || !result_stall;
    assign item_stall = !en;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LANE_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= item_valid;
            for (int i = 1; i <= LANE_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            res_vld_reg <= vld_reg[LANE_LAT];
        end
    end

    // input register with saturation, curve code alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg    <= (x > ONE_Q15) ? ONE_Q15 : x;
            op_reg[0] <= op_t'(op);
            for (int i = 1; i <= LANE_LAT; i++)
            begin
                op_reg[i] <= op_reg[i-1];
            end
            y_reg <= y_sel;
        end
    end

    eic_power u_power (
        .clk (clk),
        .en  (en),
        .op  (op_reg[0]),
        .x   (x0_reg),
        .y   (y_pow)
    );

    eic_sine u_sine (
        .clk (clk),
        .en  (en),
        .x   (x0_reg),
        .y   (y_sin)
    );

    eic_exp u_exp (
        .clk (clk),
        .en  (en),
        .x   (x0_reg),
        .y   (y_exp)
    );

    eic_circ u_circ (
        .clk (clk),
        .en  (en),
        .x   (x0_reg),
        .y   (y_circ)
    );

    // lane select
    always_comb
    begin
        case (op_reg[LANE_LAT])
            OP_SINE: y_sel = y_sin;
            OP_EXP:  y_sel = y_exp;
            OP_CIRC: y_sel = y_circ;
            default: y_sel = y_pow;
        endcase
    end

    assign result_valid = res_vld_reg;
    assign y            = y_reg;

endmodule

// ===== rtl/eic_checker.sv =====
// ----------------------------------------------------------------------------
// eic_checker: port-level checks for the ease-in curve unit
// Watches the two channels and the result range; bound to the top level.
// ----------------------------------------------------------------------------
module eic_checker
    import eic_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic [2:0]  op,
    input logic [15:0] x,
    input logic        result_valid,
    input logic        result_stall,
    input logic [15:0] y
);

    // a stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(y))
        else $error("stalled result changed");

    // input back-pressure only comes from a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a held result");

    // every curve stays within zero to one
    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> y <= ONE_Q15)
        else $error("result above one");

endmodule

bind ease_in_curve_unit eic_checker u_eic_checker (.*);

// ===== tb/ease_in_checker.sv =====
// ----------------------------------------------------------------------------
// ease_in_checker: result predictor and comparator for the ease-in curve unit
// Watches both channels, works out the eased value of every accepted
// transaction in bit-exact fixed point and compares results in order.
// ----------------------------------------------------------------------------
module ease_in_checker
    import eic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [2:0]  op,
    input  logic [15:0] x,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [15:0] y,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] UNIT30 = 64'd1 << 30;

    logic [15:0] expected_y [$];
    int          mismatches;

    // rounding right shift, half rounds up
    function automatic logic [63:0] rshift_round(logic [63:0] v, int s);
        if (s == 0)
            return v;
        if (s >= 63)
            return 64'd0;
        return (v + (64'd1 << (s - 1))) >> s;
    endfunction

    // x^n with rounding back to Q15 after each multiply
    function automatic logic [63:0] power_of(logic [63:0] p, int n);
        logic [63:0] acc;
        acc = p;
        for (int i = 1; i < n; i++)
            acc = rshift_round(acc * p, FRAC_BITS);
        return acc;
    endfunction

    // 1 - cos(pi*x/2) by a truncated series in Q30
    function automatic logic [63:0] sine_ease(logic [63:0] p);
        logic [63:0]        ang;
        longint             ang2;
        longint             h;
        longint             prod;
        longint             q;
        longint             dv;
        ang  = ((p << 15) * 64'd1686629713) >> 30;
        ang2 = longint'((ang * ang) >> 30);
        h    = longint'(UNIT30);
        for (int k = 7; k >= 1; k--)
        begin
            dv   = (2 * k) * (2 * k - 1);
            prod = ang2 * h;
            q    = (prod >= 0) ? (prod / dv) : -((-prod) / dv);
            h    = longint'(UNIT30) - (q >>> 30);
        end
        if (h < 0)
            h = 0;
        if (h > longint'(UNIT30))
            h = longint'(UNIT30);
        return rshift_round(UNIT30 - 64'(h), 15);
    endfunction

    // 2^(10x-10) by splitting off the integer power
    function automatic logic [63:0] exp_ease(logic [63:0] p);
        logic [63:0] neg;
        logic [63:0] kk;
        logic [63:0] r;
        logic [63:0] z;
        logic [63:0] acc;
        if (p == 0)
            return 64'd0;
        neg = 64'd10 * UNIT30 - 64'd10 * (p << 15);
        kk  = (neg + UNIT30 - 1) >> 30;
        r   = (kk << 30) - neg;
        z   = (r * 64'd744261118) >> 30;
        acc = UNIT30;
        for (int n = 12; n >= 1; n--)
            acc = UNIT30 + ((z * acc) >> 30) / n;
        return rshift_round(acc, int'(kk) + 15);
    endfunction

    // 1 - sqrt(1 - x^2) with the root rounded to nearest
    function automatic logic [63:0] circ_ease(logic [63:0] p);
        logic [63:0] d;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        d   = (64'd1 << 30) - p * p;
        v   = d;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        if (d - res * res > res)
            res++;
        return (64'd1 << 15) - res;
    endfunction

    // eased value for one transaction
    function automatic logic [15:0] eased_value(op_t curve, logic [15:0] xin);
        logic [63:0] p;
        logic [63:0] r;
        p = (xin > ONE_Q15) ? 64'(ONE_Q15) : 64'(xin);
        case (curve)
            OP_LINEAR:  r = p;
            OP_SINE:    r = sine_ease(p);
            OP_QUAD:    r = power_of(p, 2);
            OP_CUBIC:   r = power_of(p, 3);
            OP_QUARTIC: r = power_of(p, 4);
            OP_QUINTIC: r = power_of(p, 5);
            OP_EXP:     r = exp_ease(p);
            default:    r = circ_ease(p);
        endcase
        return r[15:0];
    endfunction

    assign pending = expected_y.size();

    // predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count   <= 0;
            mismatches   <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_y.push_back(eased_value(op_t'(op), x));
            if (result_valid && !result_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_y.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    $display("unexpected result y=%0d", y);
                end
                else
                begin
                    if (y !== expected_y[0])
                    begin
                        fail_count <= fail_count + 1;
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("y mismatch: expected %0d got %0d",
                                     expected_y[0], y);
                    end
                    void'(expected_y.pop_front());
                end
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the ease-in curve unit
// Drives directed corner cases and random curve/progress transactions with
// random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import eic_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1430;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [2:0]  op = '0;
    logic [15:0] x = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [15:0] y;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          sent = 0;
    int          idle_cycles = 0;
    bit          stall_enable = 1'b1;

    always #6 clk = ~clk;

    ease_in_curve_unit dut (.*);

    ease_in_checker checker_i (.*);

    // send one transaction, after a random gap when gaps is set
    task automatic send_item(op_t curve, logic [15:0] xin, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        op         <= curve;
        x          <= xin;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent++;
    endtask

    // receiver stalls: random lengths, with quiet stretches
    initial
    begin
        int wait_len;
        @(posedge rst_n);
        forever
        begin
            wait_len = $urandom_range(0, 11);
            result_stall <= stall_enable && ($urandom_range(0, 3) == 0);
            repeat (wait_len + 1) @(posedge clk);
        end
    end

    // watchdog on cycles with no accepted transaction or result
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired, %0d results pending", pending);
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] xv;
        logic [15:0] edges [8] = '{16'd0, 16'd1, 16'h4000, 16'h7FFF, 16'h8000,
                                   16'h8001, 16'hFFFF, 16'h5555};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every curve at zero, one and mid progress; linear, cubic and exponential above one
        foreach (edges[i])
            for (int c = 0; c < 8; c += (i < 5) ? 1 : 3)
                send_item(op_t'(c), edges[i], 1'b0);

        // random: mostly in range, some above one, some bursts
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 400)
                stall_enable = 1'b0;
            if (n == 600)
                stall_enable = 1'b1;
            case ($urandom_range(0, 9))
                0:       xv = 16'($urandom_range(0, 65535));
                1:       xv = 16'($urandom_range(0, 16));
                2:       xv = 16'($urandom_range(32752, 32768));
                default: xv = 16'($urandom_range(0, 32768));
            endcase
            send_item(op_t'($urandom_range(0, 7)), xv,
                      !(n >= 800 && n < 1000));
        end
        item_valid <= 1'b0;

        // drain, then allow for the pipeline depth
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("sent %0d transactions over all eight curves, %0d results checked",
                 sent, results_seen);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
